>>> sv/mts_pkg.sv
package mts_pkg;

  localparam int GEN_BITS_DEF = 24;
  localparam int LIMIT_W      = 48;
  localparam int LEG_W        = 49;
  localparam int ROOT_W       = 51;
  localparam int STATUS_W     = 3;
  localparam int LO_W         = 25;
  localparam int HI_W         = LEG_W - LO_W;
  localparam int P_W          = 2 * LEG_W;
  localparam int S_W          = 2 * ROOT_W;
  localparam logic [LIMIT_W-1:0] A_LIMIT_RST = LIMIT_W'(500000);

  // squares mod 64: 0 1 4 9 16 17 25 33 36 41 49 57
  localparam logic [63:0] SQ64_MASK = 64'h0202_0212_0203_0213;

  typedef enum logic [STATUS_W-1:0] {
    ST_BAD_PAIR     = 3'd0,
    ST_OVER_LIMIT   = 3'd1,
    ST_D_NOT_POS    = 3'd2,
    ST_NOT_COPRIME  = 3'd3,
    ST_MOD_REJECT   = 3'd4,
    ST_NOT_SQUARE   = 3'd5,
    ST_SOLUTION     = 3'd6
  } status_t;

  typedef struct packed {
    logic             done;
    status_t          status;
    logic [LEG_W-1:0] leg_a;
    logic [LEG_W-1:0] leg_c;
    logic [LEG_W-1:0] leg_d;
  } item_t;

  function automatic logic sq_mod64(input logic [5:0] v);
    return SQ64_MASK[v];
  endfunction

endpackage

>>> sv/mts_in_if.sv
interface mts_in_if #(
  parameter int GEN_BITS = mts_pkg::GEN_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic [GEN_BITS-1:0] gen_m;
  logic [GEN_BITS-1:0] gen_n;

  modport source (output valid, output gen_m, output gen_n, input ready);
  modport sink   (input valid, input gen_m, input gen_n, output ready);
endinterface

>>> sv/mts_out_if.sv
interface mts_out_if;
  logic                          valid;
  logic                          ready;
  logic [mts_pkg::STATUS_W-1:0]  status;
  logic [mts_pkg::LEG_W-1:0]     leg_a;
  logic [mts_pkg::LEG_W-1:0]     leg_c;
  logic [mts_pkg::LEG_W-1:0]     leg_d;
  logic [mts_pkg::ROOT_W-1:0]    root;

  modport source (output valid, output status, output leg_a, output leg_c, output leg_d,
                  output root, input ready);
  modport sink   (input valid, input status, input leg_a, input leg_c, input leg_d,
                  input root, output ready);
endinterface

>>> sv/mts_front.sv
module mts_front #(
  parameter int GEN_BITS = mts_pkg::GEN_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [GEN_BITS-1:0]          in_m,
  input  logic [GEN_BITS-1:0]          in_n,
  input  logic [mts_pkg::LIMIT_W-1:0]  a_limit,
  output logic                         out_valid,
  output mts_pkg::item_t               out_item,
  output logic [GEN_BITS-1:0]          out_gx,
  output logic [GEN_BITS-1:0]          out_gy
);
  localparam int PW = 2 * GEN_BITS;
  localparam int XW = (PW + 2 > 50) ? PW + 2 : 50;

  logic [3:0]          v_r;
  logic [GEN_BITS-1:0] m1_r, n1_r;
  logic                ok1_r, ok2_r, ok3_r;
  logic [PW-1:0]       mn2_r, mm2_r, nn2_r;
  logic [GEN_BITS-1:0] gx2_r, gy2_r, gx3_r, gy3_r, gx4_r, gy4_r;
  logic [XW-1:0]       a3_r, c3_r;
  logic                over3_r;
  logic [XW-1:0]       two_a, d_full;
  logic                dnp, alive;
  mts_pkg::item_t      item_nxt, item4_r;

  always_comb begin
    two_a = a3_r << 1;
    dnp   = c3_r >= two_a;
    d_full = two_a - c3_r;
    alive = ok3_r && !over3_r;
    item_nxt.done  = !alive || dnp;
    priority if (!ok3_r) begin
      item_nxt.status = mts_pkg::ST_BAD_PAIR;
    end else if (over3_r) begin
      item_nxt.status = mts_pkg::ST_OVER_LIMIT;
    end else if (dnp) begin
      item_nxt.status = mts_pkg::ST_D_NOT_POS;
    end else begin
      item_nxt.status = mts_pkg::ST_NOT_COPRIME;
    end
    item_nxt.leg_a = alive ? a3_r[mts_pkg::LEG_W-1:0] : '0;
    item_nxt.leg_c = alive ? c3_r[mts_pkg::LEG_W-1:0] : '0;
    item_nxt.leg_d = (alive && !dnp) ? d_full[mts_pkg::LEG_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_r    <= in_m;
      n1_r    <= in_n;
      ok1_r   <= (in_m > in_n) && (in_m[0] ^ in_n[0]);
      ok2_r   <= ok1_r;
      mn2_r   <= PW'(m1_r) * PW'(n1_r);
      mm2_r   <= PW'(m1_r) * PW'(m1_r);
      nn2_r   <= PW'(n1_r) * PW'(n1_r);
      gx2_r   <= m1_r[0] ? m1_r : n1_r;
      gy2_r   <= m1_r[0] ? n1_r : m1_r;
      ok3_r   <= ok2_r;
      a3_r    <= XW'({mn2_r, 1'b0});
      c3_r    <= XW'(mm2_r - nn2_r);
      over3_r <= XW'({mn2_r, 1'b0}) > XW'(a_limit);
      gx3_r   <= gx2_r;
      gy3_r   <= gy2_r;
      item4_r <= item_nxt;
      gx4_r   <= gx3_r;
      gy4_r   <= gy3_r;
    end
  end

  assign out_valid = v_r[3];
  assign out_item  = item4_r;
  assign out_gx    = gx4_r;
  assign out_gy    = gy4_r;
endmodule

>>> sv/mts_gcd.sv
module mts_gcd #(
  parameter int GEN_BITS = mts_pkg::GEN_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  mts_pkg::item_t      in_item,
  input  logic [GEN_BITS-1:0] in_x,
  input  logic [GEN_BITS-1:0] in_y,
  output logic                out_valid,
  output mts_pkg::item_t      out_item,
  output logic                out_coprime
);
  // binary gcd, x kept odd, one reduction per stage
  localparam int STAGES = 2 * GEN_BITS + 2;

  logic [STAGES-1:0]   v_r;
  mts_pkg::item_t      item_r [STAGES];
  logic [GEN_BITS-1:0] x_r    [STAGES];
  logic [GEN_BITS-1:0] y_r    [STAGES];
  logic [GEN_BITS-1:0] x_src  [STAGES];
  logic [GEN_BITS-1:0] y_src  [STAGES];
  logic [GEN_BITS-1:0] x_nxt  [STAGES];
  logic [GEN_BITS-1:0] y_nxt  [STAGES];

  always_comb begin
    x_src[0] = in_x;
    y_src[0] = in_y;
    for (int k = 1; k < STAGES; k++) begin
      x_src[k] = x_r[k-1];
      y_src[k] = y_r[k-1];
    end
    for (int k = 0; k < STAGES; k++) begin
      x_nxt[k] = x_src[k];
      y_nxt[k] = y_src[k];
      if (y_src[k] == '0) begin
        y_nxt[k] = '0;
      end else if (!y_src[k][0]) begin
        y_nxt[k] = y_src[k] >> 1;
      end else if (y_src[k] >= x_src[k]) begin
        y_nxt[k] = (y_src[k] - x_src[k]) >> 1;
      end else begin
        x_nxt[k] = y_src[k];
        y_nxt[k] = (x_src[k] - y_src[k]) >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r[0] <= in_item;
      for (int k = 1; k < STAGES; k++) begin
        item_r[k] <= item_r[k-1];
      end
      for (int k = 0; k < STAGES; k++) begin
        x_r[k] <= x_nxt[k];
        y_r[k] <= y_nxt[k];
      end
    end
  end

  assign out_valid   = v_r[STAGES-1];
  assign out_item    = item_r[STAGES-1];
  assign out_coprime = x_r[STAGES-1] == GEN_BITS'(1);
endmodule

>>> sv/mts_sq.sv
module mts_sq (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  mts_pkg::item_t           in_item,
  input  logic                     in_coprime,
  output logic                     out_valid,
  output mts_pkg::item_t           out_item,
  output logic [mts_pkg::S_W-1:0]  out_s
);
  localparam int LO = mts_pkg::LO_W;
  localparam int HI = mts_pkg::HI_W;
  localparam int PW = mts_pkg::P_W;
  localparam int SW = mts_pkg::S_W;

  logic [2:0]         v_r;
  mts_pkg::item_t     item_in, item1_r, item2_r, item_nxt, item3_r;
  logic [2*HI-1:0]    ahh1_r, dhh1_r;
  logic [HI+LO-1:0]   ahl1_r, dhl1_r;
  logic [2*LO-1:0]    all1_r, dll1_r;
  logic [PW-1:0]      asq2_r, dsq2_r;
  logic [SW-1:0]      s_sum, s3_r;

  always_comb begin
    item_in = in_item;
    if (!in_item.done && !in_coprime) begin
      item_in.done   = 1'b1;
      item_in.status = mts_pkg::ST_NOT_COPRIME;
    end
    s_sum    = SW'(asq2_r) + SW'(dsq2_r);
    item_nxt = item2_r;
    if (!item2_r.done && !mts_pkg::sq_mod64(s_sum[5:0])) begin
      item_nxt.done   = 1'b1;
      item_nxt.status = mts_pkg::ST_MOD_REJECT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item1_r <= item_in;
      ahh1_r  <= (2*HI)'(in_item.leg_a[LO+:HI]) * (2*HI)'(in_item.leg_a[LO+:HI]);
      ahl1_r  <= (HI+LO)'(in_item.leg_a[LO+:HI]) * (HI+LO)'(in_item.leg_a[LO-1:0]);
      all1_r  <= (2*LO)'(in_item.leg_a[LO-1:0]) * (2*LO)'(in_item.leg_a[LO-1:0]);
      dhh1_r  <= (2*HI)'(in_item.leg_d[LO+:HI]) * (2*HI)'(in_item.leg_d[LO+:HI]);
      dhl1_r  <= (HI+LO)'(in_item.leg_d[LO+:HI]) * (HI+LO)'(in_item.leg_d[LO-1:0]);
      dll1_r  <= (2*LO)'(in_item.leg_d[LO-1:0]) * (2*LO)'(in_item.leg_d[LO-1:0]);
      item2_r <= item1_r;
      asq2_r  <= PW'({ahh1_r, {(2*LO){1'b0}}}) + PW'({ahl1_r, {(LO+1){1'b0}}})
                 + PW'(all1_r);
      dsq2_r  <= PW'({dhh1_r, {(2*LO){1'b0}}}) + PW'({dhl1_r, {(LO+1){1'b0}}})
                 + PW'(dll1_r);
      item3_r <= item_nxt;
      s3_r    <= s_sum;
    end
  end

  assign out_valid = v_r[2];
  assign out_item  = item3_r;
  assign out_s     = s3_r;
endmodule

>>> sv/mts_isqrt.sv
module mts_isqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  mts_pkg::item_t              in_item,
  input  logic [mts_pkg::S_W-1:0]     in_s,
  output logic                        out_valid,
  output mts_pkg::item_t              out_item,
  output logic [mts_pkg::ROOT_W-1:0]  out_root,
  output logic                        out_exact
);
  // restoring square root, one root bit per stage
  localparam int STAGES = mts_pkg::ROOT_W;
  localparam int RW     = mts_pkg::ROOT_W + 2;
  localparam int SW     = mts_pkg::S_W;
  localparam int QW     = mts_pkg::ROOT_W;

  logic [STAGES-1:0] v_r;
  mts_pkg::item_t    item_r   [STAGES];
  logic [RW-1:0]     rem_r    [STAGES];
  logic [QW-1:0]     root_r   [STAGES];
  logic [SW-1:0]     s_r      [STAGES];
  logic [RW-1:0]     rem_src  [STAGES];
  logic [QW-1:0]     root_src [STAGES];
  logic [SW-1:0]     s_src    [STAGES];
  logic [RW-1:0]     cand     [STAGES];
  logic [RW-1:0]     trial    [STAGES];
  logic [RW-1:0]     rem_nxt  [STAGES];
  logic [QW-1:0]     root_nxt [STAGES];

  always_comb begin
    rem_src[0]  = '0;
    root_src[0] = '0;
    s_src[0]    = in_s;
    for (int k = 1; k < STAGES; k++) begin
      rem_src[k]  = rem_r[k-1];
      root_src[k] = root_r[k-1];
      s_src[k]    = s_r[k-1];
    end
    for (int k = 0; k < STAGES; k++) begin
      cand[k]  = {rem_src[k][RW-3:0], s_src[k][SW-1 -: 2]};
      trial[k] = {root_src[k], 2'b01};
      if (cand[k] >= trial[k]) begin
        rem_nxt[k]  = cand[k] - trial[k];
        root_nxt[k] = {root_src[k][QW-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = cand[k];
        root_nxt[k] = {root_src[k][QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r[0] <= in_item;
      for (int k = 1; k < STAGES; k++) begin
        item_r[k] <= item_r[k-1];
      end
      for (int k = 0; k < STAGES; k++) begin
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        s_r[k]    <= s_src[k] << 2;
      end
    end
  end

  assign out_valid = v_r[STAGES-1];
  assign out_item  = item_r[STAGES-1];
  assign out_root  = root_r[STAGES-1];
  assign out_exact = rem_r[STAGES-1] == '0;
endmodule

>>> sv/midline_triple_square_test.sv
// channel   dir  handshake        payload
// in_chan   in   valid/ready      gen_m, gen_n
// out_chan  out  valid/ready      status, leg_a, leg_c, leg_d, root
// cfg       in   cfg_we           cfg_wdata (a_limit)
//
// One item per cycle while the output is not stalled. Pipeline: front,
// gcd reduction chain, wide squaring, one root bit per stage, output register.
// Synchronous active-low reset clears valid bits; a_limit resets to 500000.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
module midline_triple_square_test #(
  parameter int GEN_BITS = mts_pkg::GEN_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [mts_pkg::LIMIT_W-1:0] cfg_wdata,
  mts_in_if.sink                      in_chan,
  mts_out_if.source                   out_chan
);
  logic [mts_pkg::LIMIT_W-1:0] a_limit_r;
  logic                        en;

  logic                   f_valid, g_valid, q_valid, r_valid, g_coprime, r_exact;
  mts_pkg::item_t         f_item, g_item, q_item, r_item;
  logic [GEN_BITS-1:0]    f_gx, f_gy;
  logic [mts_pkg::S_W-1:0]    q_s;
  logic [mts_pkg::ROOT_W-1:0] r_root;

  logic                       out_valid_r;
  mts_pkg::status_t           out_status_r, status_nxt;
  logic [mts_pkg::LEG_W-1:0]  out_a_r, out_c_r, out_d_r;
  logic [mts_pkg::ROOT_W-1:0] out_root_r, root_nxt;

  assign en            = !out_valid_r || out_chan.ready;
  assign in_chan.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_limit_r <= mts_pkg::A_LIMIT_RST;
    end else if (cfg_we) begin
      a_limit_r <= cfg_wdata;
    end
  end

  mts_front #(.GEN_BITS(GEN_BITS)) u_front (
    .clk, .rst_n, .en,
    .in_valid (in_chan.valid),
    .in_m     (in_chan.gen_m),
    .in_n     (in_chan.gen_n),
    .a_limit  (a_limit_r),
    .out_valid(f_valid),
    .out_item (f_item),
    .out_gx   (f_gx),
    .out_gy   (f_gy)
  );

  mts_gcd #(.GEN_BITS(GEN_BITS)) u_gcd (
    .clk, .rst_n, .en,
    .in_valid   (f_valid),
    .in_item    (f_item),
    .in_x       (f_gx),
    .in_y       (f_gy),
    .out_valid  (g_valid),
    .out_item   (g_item),
    .out_coprime(g_coprime)
  );

  mts_sq u_sq (
    .clk, .rst_n, .en,
    .in_valid  (g_valid),
    .in_item   (g_item),
    .in_coprime(g_coprime),
    .out_valid (q_valid),
    .out_item  (q_item),
    .out_s     (q_s)
  );

  mts_isqrt u_isqrt (
    .clk, .rst_n, .en,
    .in_valid (q_valid),
    .in_item  (q_item),
    .in_s     (q_s),
    .out_valid(r_valid),
    .out_item (r_item),
    .out_root (r_root),
    .out_exact(r_exact)
  );

  always_comb begin
    if (r_item.done) begin
      status_nxt = r_item.status;
      root_nxt   = '0;
    end else begin
      status_nxt = r_exact ? mts_pkg::ST_SOLUTION : mts_pkg::ST_NOT_SQUARE;
      root_nxt   = r_root;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_status_r <= status_nxt;
      out_a_r      <= r_item.leg_a;
      out_c_r      <= r_item.leg_c;
      out_d_r      <= r_item.leg_d;
      out_root_r   <= root_nxt;
    end
  end

  assign out_chan.valid  = out_valid_r;
  assign out_chan.status = out_status_r;
  assign out_chan.leg_a  = out_a_r;
  assign out_chan.leg_c  = out_c_r;
  assign out_chan.leg_d  = out_d_r;
  assign out_chan.root   = out_root_r;

  a_early_legs_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == mts_pkg::ST_BAD_PAIR ||
                    out_status_r == mts_pkg::ST_OVER_LIMIT)
      |-> out_a_r == '0 && out_c_r == '0 && out_d_r == '0)
    else $error("legs set on early reject");

  a_dnp_d_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == mts_pkg::ST_D_NOT_POS |-> out_d_r == '0)
    else $error("leg_d set when D not positive");

  a_root_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != mts_pkg::ST_NOT_SQUARE &&
    out_status_r != mts_pkg::ST_SOLUTION |-> out_root_r == '0)
    else $error("root set on rejected item");

  a_solution_root: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == mts_pkg::ST_SOLUTION
      |-> out_root_r != '0 && out_a_r != '0)
    else $error("solution with zero root");
endmodule

>>> test/midline_triple_square_test_tb.sv
`timescale 1ns / 100ps

module midline_triple_square_test_tb;

  localparam int GB          = 24;
  localparam int LATENCY     = 4 + (2 * GB + 2) + 3 + 51 + 1;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PER_PHASE   = 327;

  typedef struct packed {
    logic [GB-1:0] m;
    logic [GB-1:0] n;
  } pair_t;

  typedef struct packed {
    mts_pkg::status_t           st;
    logic [mts_pkg::LEG_W-1:0]  a;
    logic [mts_pkg::LEG_W-1:0]  c;
    logic [mts_pkg::LEG_W-1:0]  d;
    logic [mts_pkg::ROOT_W-1:0] r;
  } verdict_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [mts_pkg::LIMIT_W-1:0] cfg_wdata;

  mts_in_if #(.GEN_BITS(GB)) in_chan ();
  mts_out_if out_chan ();

  midline_triple_square_test #(.GEN_BITS(GB)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source)
  );

  pair_t        pending_pairs[$];
  verdict_t     expected_verdicts[$];
  logic [mts_pkg::LIMIT_W-1:0] limit_shadow;
  int           errors = 0;
  int           cycle_cnt = 0;
  int           burst_left = 0;
  int           gap_left = 0;
  int           hold_left = 0;
  int           stall_mode = 0;
  logic         hold_done = 1'b0;
  pair_t        next_pair;
  verdict_t     got;
  verdict_t     want;

  function automatic verdict_t judge_pair(logic [GB-1:0] m, logic [GB-1:0] n,
                                          logic [mts_pkg::LIMIT_W-1:0] lim);
    logic [63:0]  a;
    logic [63:0]  c;
    logic [63:0]  d;
    logic [63:0]  x;
    logic [63:0]  y;
    logic [63:0]  t;
    logic [127:0] s;
    logic [50:0]  r;
    logic [50:0]  tr;
    logic         sq;
    verdict_t     v;
    v = '0;
    v.st = mts_pkg::ST_BAD_PAIR;
    if (m <= n || m[0] == n[0]) return v;
    a = 64'(m) * 64'(n) * 64'd2;
    if (a > 64'(lim)) begin
      v.st = mts_pkg::ST_OVER_LIMIT;
      return v;
    end
    c = 64'(m) * 64'(m) - 64'(n) * 64'(n);
    v.a = a[mts_pkg::LEG_W-1:0];
    v.c = c[mts_pkg::LEG_W-1:0];
    if (c >= 2 * a) begin
      v.st = mts_pkg::ST_D_NOT_POS;
      return v;
    end
    d = 2 * a - c;
    v.d = d[mts_pkg::LEG_W-1:0];
    x = 64'(m);
    y = 64'(n);
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    if (x != 1) begin
      v.st = mts_pkg::ST_NOT_COPRIME;
      return v;
    end
    s = 128'(a) * 128'(a) + 128'(d) * 128'(d);
    sq = 1'b0;
    for (int i = 0; i < 64; i++)
      if (((i * i) & 63) == int'(s[5:0])) sq = 1'b1;
    if (!sq) begin
      v.st = mts_pkg::ST_MOD_REJECT;
      return v;
    end
    r = '0;
    for (int b = 50; b >= 0; b--) begin
      tr = r | (51'd1 << b);
      if (128'(tr) * 128'(tr) <= s) r = tr;
    end
    v.r = r;
    v.st = (128'(r) * 128'(r) == s) ? mts_pkg::ST_SOLUTION : mts_pkg::ST_NOT_SQUARE;
    return v;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sender: bursts with gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_chan.valid && in_chan.ready)
        expected_verdicts.push_back(judge_pair(in_chan.gen_m, in_chan.gen_n, limit_shadow));
      if (!in_chan.valid || in_chan.ready) begin
        if (burst_left == 0) begin
          if (gap_left > 0) begin
            gap_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
        if (burst_left > 0 && pending_pairs.size() > 0) begin
          next_pair = pending_pairs.pop_front();
          in_chan.gen_m <= next_pair.m;
          in_chan.gen_n <= next_pair.n;
          in_chan.valid <= 1'b1;
          burst_left--;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: changing stall pattern, one long hold-off while items are queued
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt % 256 == 0) stall_mode = $urandom_range(0, 3);
    if (!hold_done && pending_pairs.size() > 200) begin
      hold_left = 600;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_chan.ready <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_chan.ready <= 1'b1;
        1: out_chan.ready <= $urandom_range(0, 1);
        2: out_chan.ready <= (cycle_cnt % 4 == 0);
        default: out_chan.ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got.st = mts_pkg::status_t'(out_chan.status);
      got.a  = out_chan.leg_a;
      got.c  = out_chan.leg_c;
      got.d  = out_chan.leg_d;
      got.r  = out_chan.root;
      if (expected_verdicts.size() == 0) begin
        $display("%0t: unexpected item, actual %p", $time, got);
        errors++;
      end else begin
        want = expected_verdicts.pop_front();
        if (got.st != want.st) begin
          $display("%0t: status expected %0d actual %0d", $time, want.st, got.st);
          errors++;
        end
        if (got.a != want.a) begin
          $display("%0t: leg_a expected %0d actual %0d", $time, want.a, got.a);
          errors++;
        end
        if (got.c != want.c) begin
          $display("%0t: leg_c expected %0d actual %0d", $time, want.c, got.c);
          errors++;
        end
        if (got.d != want.d) begin
          $display("%0t: leg_d expected %0d actual %0d", $time, want.d, got.d);
          errors++;
        end
        if (got.r != want.r) begin
          $display("%0t: root expected %0d actual %0d", $time, want.r, got.r);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic push_pair(logic [63:0] m, logic [63:0] n);
    pair_t p;
    p.m = m[GB-1:0];
    p.n = n[GB-1:0];
    pending_pairs.push_back(p);
  endtask

  task automatic write_limit(logic [mts_pkg::LIMIT_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    limit_shadow = v;
  endtask

  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (pending_pairs.size() != 0 || in_chan.valid || expected_verdicts.size() != 0);
  endtask

  task automatic add_random_pair();
    int          pick;
    logic [63:0] n;
    logic [63:0] m;
    logic [63:0] kmax;
    int          nmax;
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      case ($urandom_range(0, 3))
        0: nmax = 200;
        1: nmax = 3000;
        2: nmax = 100000;
        default: nmax = 3900000;
      endcase
      n = 64'($urandom_range(1, nmax));
      kmax = (n * 3236) / 1000;
      if (kmax < 1) kmax = 1;
      m = n + 64'($urandom_range(1, 32'(kmax)) | 1);
      if ($urandom_range(0, 9) == 0 && m * 3 < (64'd1 << GB)) begin
        m = m * 3;
        n = n * 3;
      end
      push_pair(m, n);
    end else if (pick == 7) begin
      n = 64'($urandom_range(0, 3000000));
      push_pair(n * 64'($urandom_range(4, 5)) + 64'($urandom_range(0, 1)), n);
    end else begin
      push_pair(64'($urandom), 64'($urandom));
    end
  endtask

  initial begin
    logic [mts_pkg::LIMIT_W-1:0] limits[5];
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    limit_shadow   = mts_pkg::A_LIMIT_RST;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    push_pair(5, 5);
    push_pair(8, 4);
    push_pair(3, 7);
    push_pair(0, 0);
    push_pair(3, 0);
    push_pair(9, 6);
    push_pair(2, 1);
    push_pair(5, 2);
    push_pair(500, 499);
    push_pair(24'hFFFFFF, 24'hFFFFFE);
    wait_drained();

    limits[0] = {mts_pkg::LIMIT_W{1'b1}};
    limits[1] = 48'd1;
    limits[2] = 48'd500000;
    limits[3] = mts_pkg::LIMIT_W'({$urandom, $urandom});
    limits[4] = mts_pkg::LIMIT_W'($urandom_range(1, 1 << 20));
    foreach (limits[i]) begin
      write_limit(limits[i]);
      if (i == 0) begin
        push_pair(24'hFFFFFF, 24'hFFFFFE);
        push_pair(24'hFFFFFF, 0);
        push_pair(24'hFFFFFE, 24'h3FFFFF);
        push_pair(24'hFFFFFF, 24'h3FFFFE);
        push_pair(24'h800000, 24'h7FFFFF);
        push_pair(24'hAAAAAB, 24'h555554);
      end
      for (int k = 0; k < PER_PHASE; k++) add_random_pair();
      wait_drained();
    end

    repeat (LATENCY + 20) @(posedge clk);
    if (errors == 0 && expected_verdicts.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
